[hdl/avg_pool_2x2_downscale_unit_macros.svh]
// assertion macros shared by the 2x2 average pooling rtl
`ifndef AVG_POOL_2X2_DOWNSCALE_UNIT_MACROS_SVH
`define AVG_POOL_2X2_DOWNSCALE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define AVGP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define AVGP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/avgp_pkg.sv]
// shared constants and types for the 2x2 average pooling unit
package avgp_pkg;

    localparam int MAX_COLS_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_ROWS        = 4096;

    localparam int ROW_W          = 12;
    localparam int ROW_WIDTH_W    = 11;
    localparam int FRAME_ROWS_W   = 13;
    localparam int CMP_W          = 14;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROW_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME_ROWS = 1'd1;

    localparam logic [ROW_WIDTH_W-1:0]  ROW_WIDTH_RST  = 11'd1024;
    localparam logic [FRAME_ROWS_W-1:0] FRAME_ROWS_RST = 13'd1024;

    // scan position flags for the word being accepted
    typedef struct packed {
        logic odd_col;
        logic odd_row;
        logic last_col;
        logic last_row;
    } t_scan;

endpackage

[hdl/avgp_sample_if.sv]
// input sample channel
interface avgp_sample_if import avgp_pkg::*; #(
    parameter int W = SAMPLE_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

[hdl/avgp_result_if.sv]
// pooled result channel
interface avgp_result_if import avgp_pkg::*; #(
    parameter int W = SAMPLE_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] average;
    logic                row_end;
    logic                frame_end;

    modport source (output valid, output average, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input average, input row_end, input frame_end,
                    output ready);
endinterface

[hdl/avgp_scan_ctrl.sv]
// column and row counters with effective frame size
module avgp_scan_ctrl import avgp_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int COL_W    = 10,
    parameter int IDX_W    = 9
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic [ROW_WIDTH_W-1:0]  i_row_width,
    input  logic [FRAME_ROWS_W-1:0] i_frame_rows,
    output t_scan                   o_pos,
    output logic [IDX_W-1:0]        o_idx
);

    logic [COL_W-1:0]        r_col, n_col;
    logic [ROW_W-1:0]        r_row, n_row;
    logic [ROW_WIDTH_W-1:0]  w_even;
    logic [FRAME_ROWS_W-1:0] h_even;
    logic [CMP_W-1:0]        w_eff;
    logic [FRAME_ROWS_W-1:0] h_eff;
    logic                    last_col, last_row;

    assign w_even = {i_row_width[ROW_WIDTH_W-1:1], 1'b0};
    assign h_even = {i_frame_rows[FRAME_ROWS_W-1:1], 1'b0};

    // clamp to 2 .. max, even
    always_comb begin
        w_eff = CMP_W'(w_even);
        if (w_even == '0) begin
            w_eff = CMP_W'(2);
        end else if (CMP_W'(w_even) > CMP_W'(MAX_COLS)) begin
            w_eff = CMP_W'(MAX_COLS) & ~CMP_W'(1);
        end
        h_eff = h_even;
        if (h_even == '0) begin
            h_eff = FRAME_ROWS_W'(2);
        end else if (h_even > FRAME_ROWS_W'(MAX_ROWS)) begin
            h_eff = FRAME_ROWS_W'(MAX_ROWS);
        end
    end

    assign last_col = (CMP_W'(r_col) + CMP_W'(1)) >= w_eff;
    assign last_row = (FRAME_ROWS_W'(r_row) + FRAME_ROWS_W'(1)) >= h_eff;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_adv) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_pos.odd_col  = r_col[0];
    assign o_pos.odd_row  = r_row[0];
    assign o_pos.last_col = last_col;
    assign o_pos.last_row = last_row;
    assign o_idx          = IDX_W'(r_col >> 1);

endmodule

[hdl/avgp_line_store.sv]
// line store of horizontal pair sums, one write and one registered read port
module avgp_line_store #(
    parameter int DEPTH = 512,
    parameter int IDX_W = 9,
    parameter int DW    = 17
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [IDX_W-1:0]     i_waddr,
    input  logic signed [DW-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [IDX_W-1:0]     i_raddr,
    output logic signed [DW-1:0] o_rdata
);

    logic signed [DW-1:0] mem [DEPTH];
    logic signed [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/avg_pool_2x2_downscale_unit.sv]
// 2x2 average pooling unit, top level
//
//  channel   dir   handshake          payload
//  i_smp     in    valid / ready      sample (signed, SAMPLE_BITS)
//  o_res     out   valid / ready      average, row_end, frame_end
//  i_cfg_*   in    write enable only  idx 0 row_width, idx 1 frame_rows
//
// one word per clock sustained while the output is not stalled; a result passes
// through the line store read into the middle stage, then rounding into the output register
// the line store has one write and one read port: each odd-column word makes one write (even row) or one read (odd row)
// reset clears counters and valid flags and loads config defaults; the line store is not cleared
// an output stall first fills the middle stage, then input ready drops
module avg_pool_2x2_downscale_unit import avgp_pkg::*; #(
    parameter int MAX_COLS    = MAX_COLS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    avgp_sample_if.sink           i_smp,
    avgp_result_if.source         o_res
);

`include "avg_pool_2x2_downscale_unit_macros.svh"

    localparam int DEPTH = (MAX_COLS / 2 > 0) ? MAX_COLS / 2 : 1;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_W = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
    localparam int PW    = SAMPLE_BITS + 1;   // pair sum
    localparam int SW    = SAMPLE_BITS + 2;   // block sum

    // configuration registers
    logic [ROW_WIDTH_W-1:0]  r_row_width;
    logic [FRAME_ROWS_W-1:0] r_frame_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width  <= ROW_WIDTH_RST;
            r_frame_rows <= FRAME_ROWS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_ROW_WIDTH:  r_row_width  <= i_cfg_data[ROW_WIDTH_W-1:0];
                CFG_IDX_FRAME_ROWS: r_frame_rows <= i_cfg_data[FRAME_ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    // scan position of the word at the input
    t_scan            pos;
    logic [IDX_W-1:0] idx;
    logic             accept;

    assign accept = i_smp.valid & i_smp.ready;

    avgp_scan_ctrl #(
        .MAX_COLS (MAX_COLS),
        .COL_W    (COL_W),
        .IDX_W    (IDX_W)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (accept),
        .i_row_width  (r_row_width),
        .i_frame_rows (r_frame_rows),
        .o_pos        (pos),
        .o_idx        (idx)
    );

    // horizontal pair: even column parks the sample, odd column completes it
    logic signed [PW-1:0] r_pair;
    logic signed [PW-1:0] hsum;

    assign hsum = r_pair + PW'(i_smp.sample);

    always_ff @(posedge i_clk) begin
        if (accept && !pos.odd_col) begin
            r_pair <= PW'(i_smp.sample);
        end
    end

    // even rows write the pair sum, odd rows read the partner from the row above
    logic                 mem_we, mem_re;
    logic signed [PW-1:0] mem_rdata;

    assign mem_we = accept & pos.odd_col & ~pos.odd_row;
    assign mem_re = accept & pos.odd_col & pos.odd_row;

    avgp_line_store #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .DW    (PW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (idx),
        .i_wdata (hsum),
        .i_re    (mem_re),
        .i_raddr (idx),
        .o_rdata (mem_rdata)
    );

    // middle stage: waits for line store read data
    logic                 r_s1_valid;
    logic signed [PW-1:0] r_s1_hsum;
    logic                 r_s1_row_end, r_s1_frame_end;
    logic                 s1_adv;

    logic                        r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_avg;
    logic                        r_out_row_end, r_out_frame_end;

    assign s1_adv      = ~r_out_valid | o_res.ready;
    assign i_smp.ready = ~r_s1_valid | s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_smp.ready) begin
            r_s1_valid <= mem_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_s1_hsum      <= hsum;
            r_s1_row_end   <= pos.last_col;
            r_s1_frame_end <= pos.last_col & pos.last_row;
        end
    end

    // block sum and rounding to nearest, ties away from zero
    logic signed [SW-1:0]      bsum;
    logic [SW-1:0]             mag;
    logic [SW-1:0]             mag_rnd;
    logic [SAMPLE_BITS-1:0]    quot;
    logic signed [SAMPLE_BITS-1:0] avg;

    always_comb begin
        bsum    = SW'(mem_rdata) + SW'(r_s1_hsum);
        mag     = bsum[SW-1] ? SW'(-bsum) : SW'(bsum);
        mag_rnd = mag + SW'(2);
        quot    = mag_rnd[SW-1:2];
        avg     = bsum[SW-1] ? SAMPLE_BITS'(-quot) : quot;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_avg       <= avg;
            r_out_row_end   <= r_s1_row_end;
            r_out_frame_end <= r_s1_frame_end;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.average   = r_out_avg;
    assign o_res.row_end   = r_out_row_end;
    assign o_res.frame_end = r_out_frame_end;

    // checks
    `AVGP_ASSERT_NOW(a_frame_end_on_row_end, o_res.valid && o_res.frame_end, o_res.row_end, "frame end without row end")
    `AVGP_ASSERT_NOW(a_store_one_access, mem_we || mem_re, !(mem_we && mem_re), "line store read and write together")
    `AVGP_ASSERT_NEXT(a_read_lands_in_s1, mem_re, r_s1_valid, "line store read lost")
    `AVGP_ASSERT_NEXT(a_rdata_held, r_s1_valid && !s1_adv, $stable(mem_rdata) && r_s1_valid, "stalled read data changed")

endmodule
